@@ src/tte_pkg.sv @@
// Shared constants, types and helpers of the text terminal escape controller.
// No dependencies; every other file uses this package.
package tte_pkg;

	localparam int ROWS      = 25;
	localparam int COLS      = 80;
	localparam int ESC_LIMIT = 20;
	localparam int TAB_STEP  = 8;

	localparam int CELLS      = ROWS * COLS;
	localparam int MOVE_CELLS = (ROWS - 1) * COLS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int CH_W       = 7;
	localparam int BUF_DEPTH  = ESC_LIMIT + 1;
	localparam int IDX_W      = $clog2(BUF_DEPTH);
	localparam int LEN_W      = $clog2(ESC_LIMIT + 2);
	localparam int NUM_W      = 9;

	typedef logic [CH_W-1:0]   ch_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [NUM_W-1:0]  num_t;

	localparam num_t NUM_SAT = '1;

	localparam ch_t CH_BS    = 7'd8;
	localparam ch_t CH_TAB   = 7'd9;
	localparam ch_t CH_LF    = 7'd10;
	localparam ch_t CH_CR    = 7'd13;
	localparam ch_t CH_ESC   = 7'd27;
	localparam ch_t CH_SPACE = 7'd32;
	localparam ch_t CH_DEL   = 7'h7f;
	localparam ch_t CH_ZERO  = 7'h30;
	localparam ch_t CH_ONE   = 7'h31;
	localparam ch_t CH_TWO   = 7'h32;
	localparam ch_t CH_NINE  = 7'h39;
	localparam ch_t CH_SEMI  = 7'h3b;
	localparam ch_t CH_LBRK  = 7'h5b;
	localparam ch_t CH_UP    = 7'h41;
	localparam ch_t CH_DOWN  = 7'h42;
	localparam ch_t CH_RIGHT = 7'h43;
	localparam ch_t CH_LEFT  = 7'h44;
	localparam ch_t CH_POS_H = 7'h48;
	localparam ch_t CH_CLR_J = 7'h4a;
	localparam ch_t CH_CLR_K = 7'h4b;
	localparam ch_t CH_POS_F = 7'h66;
	localparam ch_t CH_SAVE  = 7'h73;
	localparam ch_t CH_REST  = 7'h75;

	typedef enum logic [2:0] {
		CC_NONE, CC_ESC, CC_CR, CC_LF, CC_BS, CC_TAB, CC_PRINT
	} ch_class_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_FILL, OP_LOAD, OP_OUT, OP_ESC_DROP, OP_ESC_STORE, OP_ESC_START,
		OP_CR, OP_LF, OP_BS, OP_TAB, OP_PUT, OP_PARSE, OP_APPLY, OP_REPLAY,
		OP_REPLAY_NEXT, OP_SCROLL
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_RD, ST_CHAR, ST_PARSE, ST_FILL, ST_SCROLL, ST_NEXT,
		ST_FINISH
	} tte_state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic      req_read;
		logic      esc_active;
		logic      esc_over;
		logic      ch_final;
		ch_class_t ch_class;
		logic      at_bottom;
		logic      put_wrap;
		logic      tab_wrap;
		logic      parse_done;
		logic      apply_ok;
		logic      apply_fill;
		logic      fill_done;
		logic      scroll_done;
		logic      replay_more;
		logic      out_free;
	} dp_sts_t;

	function automatic addr_t cell_addr(row_t r, col_t c);
		return ADDR_W'(int'(r) * COLS + int'(c));
	endfunction

endpackage

@@ src/tte_if.sv @@
// Request and result channel interfaces (valid/ready with payload).
// Depends on tte_pkg for field widths.
interface tte_req_if;
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	tte_pkg::ch_t          char_in;
	tte_pkg::row_t         read_row;
	tte_pkg::col_t         read_col;
	modport source(output valid, req_type, char_in, read_row, read_col, input ready);
	modport sink(input valid, req_type, char_in, read_row, read_col, output ready);
endinterface

interface tte_rsp_if;
	logic                  valid;
	logic                  ready;
	tte_pkg::ch_t          cell_char;
	tte_pkg::row_t         cursor_row;
	tte_pkg::col_t         cursor_col;
	logic                  in_escape;
	modport source(output valid, cell_char, cursor_row, cursor_col, in_escape, input ready);
	modport sink(input valid, cell_char, cursor_row, cursor_col, in_escape, output ready);
endinterface

@@ src/tte_datapath.sv @@
// Datapath: screen memory, cursor, escape buffers, parser and result register.
// Depends on tte_pkg and tte_if; driven by tte_ctrl commands.
module tte_datapath (
	input  logic              clk,
	input  logic              arst_n,
	tte_req_if.sink           req,
	tte_rsp_if.source         rsp,
	input  tte_pkg::dp_cmd_t  cmd,
	output tte_pkg::dp_sts_t  sts
);
	import tte_pkg::*;

	ch_t  screen [CELLS];
	ch_t  rdata_q;
	logic we;
	addr_t waddr, raddr;
	ch_t  wdata;

	row_t cur_row_q, saved_row_q;
	col_t cur_col_q, saved_col_q;
	logic esc_act_q;
	logic [LEN_W-1:0] esc_len_q, rlen_q, rpos_q, pos_q;
	ch_t  ebuf_q [BUF_DEPTH];
	ch_t  rbuf_q [BUF_DEPTH];
	ch_t  ch_q, fin_q;
	logic req_rd_q, rd_ok_q;
	addr_t rd_addr_q;
	logic phase_q, fail_q;
	num_t y_q, x_q;
	addr_t fill_addr_q, fill_hi_q, sidx_q;
	logic out_valid_q;
	ch_t  cell_q;
	row_t orow_q;
	col_t ocol_q;
	logic oesc_q;

	ch_class_t cls;
	logic      is_final;
	logic [COL_W:0] tab_next;
	row_t bs_row;
	col_t bs_col;
	logic home;
	addr_t cur_addr, bs_addr, row_base;
	ch_t  pb;
	logic pb_digit;
	num_t acc, acc_next;
	logic [NUM_W+3:0] acc_wide;
	num_t n;
	row_t new_row;
	col_t new_col;
	addr_t fill_lo, fill_hi;
	logic len2, len3, b0ok, b1ok, ok, fill;
	logic rd_in_range;

	// character classification
	always_comb begin
		priority if (ch_q == CH_ESC) cls = CC_ESC;
		else if (ch_q == CH_CR)      cls = CC_CR;
		else if (ch_q == CH_LF)      cls = CC_LF;
		else if (ch_q == CH_BS)      cls = CC_BS;
		else if (ch_q == CH_TAB)     cls = CC_TAB;
		else if (ch_q < CH_SPACE || ch_q == CH_DEL) cls = CC_NONE;
		else                         cls = CC_PRINT;
	end

	assign is_final = (ch_q == CH_UP) || (ch_q == CH_DOWN) || (ch_q == CH_RIGHT) ||
		(ch_q == CH_LEFT) || (ch_q == CH_POS_H) || (ch_q == CH_POS_F) ||
		(ch_q == CH_CLR_J) || (ch_q == CH_CLR_K) || (ch_q == CH_SAVE) || (ch_q == CH_REST);

	assign tab_next = (COL_W+1)'((int'(cur_col_q) / TAB_STEP + 1) * TAB_STEP);
	assign home     = (cur_row_q == '0) && (cur_col_q == '0);
	assign bs_row   = (cur_col_q == '0) ? cur_row_q - 1'b1 : cur_row_q;
	assign bs_col   = (cur_col_q == '0) ? COL_W'(COLS - 1) : cur_col_q - 1'b1;
	assign cur_addr = cell_addr(cur_row_q, cur_col_q);
	assign bs_addr  = cell_addr(bs_row, bs_col);
	assign row_base = cell_addr(cur_row_q, '0);

	// one parameter byte per cycle, decimal accumulate with saturation
	assign pb       = ebuf_q[pos_q[IDX_W-1:0]];
	assign pb_digit = (pb >= CH_ZERO) && (pb <= CH_NINE);
	assign acc      = phase_q ? x_q : y_q;
	assign acc_wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (NUM_W+4)'(pb - CH_ZERO);
	assign acc_next = (acc_wide > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT : acc_wide[NUM_W-1:0];

	// final letter evaluation
	assign len2 = (esc_len_q == LEN_W'(2));
	assign len3 = (esc_len_q == LEN_W'(3));
	assign b0ok = (ebuf_q[0] == CH_LBRK);
	assign b1ok = (ebuf_q[1] == CH_ONE) || (ebuf_q[1] == CH_TWO);
	assign n    = (y_q == '0) ? NUM_W'(1) : y_q;

	always_comb begin
		new_row = cur_row_q;
		new_col = cur_col_q;
		fill_lo = row_base;
		fill_hi = row_base + ADDR_W'(COLS - 1);
		ok      = 1'b0;
		fill    = 1'b0;
		unique case (fin_q)
			CH_UP: begin
				ok = b0ok && !fail_q;
				new_row = (n >= NUM_W'(cur_row_q)) ? '0 : cur_row_q - ROW_W'(n);
			end
			CH_DOWN: begin
				ok = b0ok && !fail_q;
				new_row = (n >= NUM_W'(ROWS - 1) - NUM_W'(cur_row_q)) ? ROW_W'(ROWS - 1)
					: cur_row_q + ROW_W'(n);
			end
			CH_RIGHT: begin
				ok = b0ok && !fail_q;
				new_col = (n >= NUM_W'(COLS - 1) - NUM_W'(cur_col_q)) ? COL_W'(COLS - 1)
					: cur_col_q + COL_W'(n);
			end
			CH_LEFT: begin
				ok = b0ok && !fail_q;
				new_col = (n >= NUM_W'(cur_col_q)) ? '0 : cur_col_q - COL_W'(n);
			end
			CH_POS_H, CH_POS_F: begin
				ok = b0ok && !fail_q;
				new_col = (x_q < NUM_W'(COLS)) ? COL_W'(x_q) : COL_W'(COLS - 1);
				new_row = (y_q < NUM_W'(ROWS)) ? ROW_W'(y_q) : ROW_W'(ROWS - 1);
			end
			CH_CLR_J: begin
				ok   = b0ok && (len2 || (len3 && b1ok));
				fill = 1'b1;
				if (len2) begin
					fill_hi = ADDR_W'(CELLS - 1);
				end else if (ebuf_q[1] == CH_ONE) begin
					fill_lo = '0;
				end else begin
					fill_lo = '0;
					fill_hi = ADDR_W'(CELLS - 1);
					new_row = '0;
					new_col = '0;
				end
			end
			CH_CLR_K: begin
				ok   = b0ok && (len2 || (len3 && b1ok));
				fill = 1'b1;
				if (len2)
					fill_lo = cur_addr;
				else if (ebuf_q[1] == CH_ONE)
					fill_hi = cur_addr;
			end
			CH_SAVE: ok = b0ok && len2;
			CH_REST: begin
				ok = b0ok && len2;
				new_row = saved_row_q;
				new_col = saved_col_q;
			end
			default: ok = 1'b0;
		endcase
	end

	// screen write and read ports
	always_comb begin
		we    = 1'b0;
		waddr = fill_addr_q;
		wdata = CH_SPACE;
		unique case (cmd.op)
			OP_FILL: we = 1'b1;
			OP_PUT: begin
				we    = 1'b1;
				waddr = cur_addr;
				wdata = ch_q;
			end
			OP_BS: begin
				we    = !home;
				waddr = bs_addr;
			end
			OP_SCROLL: begin
				we    = (sidx_q != '0);
				waddr = sidx_q - 1'b1;
				wdata = rdata_q;
			end
			default: we = 1'b0;
		endcase
		raddr = (cmd.op == OP_SCROLL && sidx_q < ADDR_W'(MOVE_CELLS))
			? sidx_q + ADDR_W'(COLS) : rd_addr_q;
	end

	always_ff @(posedge clk) begin
		if (we)
			screen[waddr] <= wdata;
		rdata_q <= screen[raddr];
	end

	assign rd_in_range = (req.read_row < ROW_W'(ROWS)) && (req.read_col < COL_W'(COLS));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			saved_row_q <= '0;
			saved_col_q <= '0;
			esc_act_q   <= 1'b0;
			esc_len_q   <= '0;
			rlen_q      <= '0;
			rpos_q      <= '0;
			fill_addr_q <= '0;
			fill_hi_q   <= ADDR_W'(CELLS - 1);
			sidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			sidx_q <= '0;
			unique case (cmd.op)
				OP_FILL: fill_addr_q <= fill_addr_q + 1'b1;
				OP_OUT: out_valid_q <= 1'b1;
				OP_ESC_DROP: begin
					esc_act_q <= 1'b0;
					esc_len_q <= '0;
				end
				OP_ESC_STORE: esc_len_q <= esc_len_q + 1'b1;
				OP_ESC_START: begin
					esc_act_q <= 1'b1;
					esc_len_q <= '0;
				end
				OP_CR: cur_col_q <= '0;
				OP_LF: begin
					if (cur_row_q != ROW_W'(ROWS - 1))
						cur_row_q <= cur_row_q + 1'b1;
				end
				OP_BS: begin
					if (!home) begin
						cur_row_q <= bs_row;
						cur_col_q <= bs_col;
					end
				end
				OP_TAB: begin
					if (tab_next >= (COL_W+1)'(COLS)) begin
						cur_col_q <= '0;
						if (cur_row_q != ROW_W'(ROWS - 1))
							cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= tab_next[COL_W-1:0];
					end
				end
				OP_PUT: begin
					if (cur_col_q == COL_W'(COLS - 1)) begin
						cur_col_q <= '0;
						if (cur_row_q != ROW_W'(ROWS - 1))
							cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				OP_APPLY: begin
					cur_row_q <= new_row;
					cur_col_q <= new_col;
					if (fin_q == CH_SAVE) begin
						saved_row_q <= cur_row_q;
						saved_col_q <= cur_col_q;
					end
					fill_addr_q <= fill_lo;
					fill_hi_q   <= fill_hi;
					esc_act_q   <= 1'b0;
					esc_len_q   <= '0;
				end
				OP_REPLAY: begin
					rlen_q    <= esc_len_q;
					rpos_q    <= '0;
					esc_act_q <= 1'b0;
					esc_len_q <= '0;
				end
				OP_REPLAY_NEXT: rpos_q <= rpos_q + 1'b1;
				OP_SCROLL: begin
					sidx_q <= sidx_q + 1'b1;
					if (sidx_q == ADDR_W'(MOVE_CELLS)) begin
						fill_addr_q <= ADDR_W'(MOVE_CELLS);
						fill_hi_q   <= ADDR_W'(CELLS - 1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_rd_q  <= req.req_type;
				ch_q      <= req.char_in;
				rd_ok_q   <= rd_in_range;
				rd_addr_q <= rd_in_range ? cell_addr(req.read_row, req.read_col) : '0;
			end
			OP_OUT: begin
				cell_q <= (req_rd_q && rd_ok_q) ? rdata_q : '0;
				orow_q <= cur_row_q;
				ocol_q <= cur_col_q;
				oesc_q <= esc_act_q;
			end
			OP_ESC_STORE: begin
				ebuf_q[esc_len_q[IDX_W-1:0]] <= ch_q;
				fin_q   <= ch_q;
				pos_q   <= LEN_W'(1);
				phase_q <= 1'b0;
				fail_q  <= 1'b0;
				y_q     <= '0;
				x_q     <= '0;
			end
			OP_PARSE: begin
				pos_q <= pos_q + 1'b1;
				if (pb_digit) begin
					if (phase_q) x_q <= acc_next;
					else         y_q <= acc_next;
				end else if (pb == CH_SEMI && !phase_q &&
					(fin_q == CH_POS_H || fin_q == CH_POS_F)) begin
					phase_q <= 1'b1;
				end else begin
					fail_q <= 1'b1;
				end
			end
			OP_REPLAY: rbuf_q <= ebuf_q;
			OP_REPLAY_NEXT: ch_q <= rbuf_q[rpos_q[IDX_W-1:0]];
			default: ;
		endcase
	end

	assign sts.req_read    = req.req_type;
	assign sts.esc_active  = esc_act_q;
	assign sts.esc_over    = esc_len_q > LEN_W'(ESC_LIMIT);
	assign sts.ch_final    = is_final;
	assign sts.ch_class    = cls;
	assign sts.at_bottom   = cur_row_q == ROW_W'(ROWS - 1);
	assign sts.put_wrap    = cur_col_q == COL_W'(COLS - 1);
	assign sts.tab_wrap    = tab_next >= (COL_W+1)'(COLS);
	assign sts.parse_done  = ({1'b0, pos_q} + 1'b1) >= {1'b0, esc_len_q};
	assign sts.apply_ok    = ok;
	assign sts.apply_fill  = fill;
	assign sts.fill_done   = fill_addr_q == fill_hi_q;
	assign sts.scroll_done = sidx_q == ADDR_W'(MOVE_CELLS);
	assign sts.replay_more = rpos_q < rlen_q;
	assign sts.out_free    = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_char  = cell_q;
	assign rsp.cursor_row = orow_q;
	assign rsp.cursor_col = ocol_q;
	assign rsp.in_escape  = oesc_q;

endmodule

@@ src/tte_ctrl.sv @@
// Controller state machine: sequences the datapath one operation per cycle.
// Depends on tte_pkg.
module tte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tte_pkg::dp_sts_t  sts,
	output tte_pkg::dp_cmd_t  cmd
);
	import tte_pkg::*;

	tte_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:   if (sts.fill_done) state_d = ST_IDLE;
			ST_IDLE:   if (req_valid) state_d = sts.req_read ? ST_RD : ST_CHAR;
			ST_RD:     state_d = ST_FINISH;
			ST_CHAR: begin
				if (sts.esc_active) begin
					state_d = (!sts.esc_over && sts.ch_final) ? ST_PARSE : ST_NEXT;
				end else begin
					unique case (sts.ch_class)
						CC_LF:    state_d = sts.at_bottom ? ST_SCROLL : ST_NEXT;
						CC_TAB:   state_d = (sts.tab_wrap && sts.at_bottom) ? ST_SCROLL : ST_NEXT;
						CC_PRINT: state_d = (sts.put_wrap && sts.at_bottom) ? ST_SCROLL : ST_NEXT;
						default:  state_d = ST_NEXT;
					endcase
				end
			end
			ST_PARSE: begin
				if (sts.parse_done)
					state_d = (sts.apply_ok && sts.apply_fill) ? ST_FILL : ST_NEXT;
			end
			ST_FILL:   if (sts.fill_done) state_d = ST_NEXT;
			ST_SCROLL: if (sts.scroll_done) state_d = ST_FILL;
			ST_NEXT:   state_d = sts.replay_more ? ST_CHAR : ST_FINISH;
			ST_FINISH: if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			ST_INIT: cmd.op = OP_FILL;
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd.op = OP_LOAD;
			end
			ST_CHAR: begin
				if (sts.esc_active) begin
					cmd.op = sts.esc_over ? OP_ESC_DROP : OP_ESC_STORE;
				end else begin
					unique case (sts.ch_class)
						CC_ESC:   cmd.op = OP_ESC_START;
						CC_CR:    cmd.op = OP_CR;
						CC_LF:    cmd.op = OP_LF;
						CC_BS:    cmd.op = OP_BS;
						CC_TAB:   cmd.op = OP_TAB;
						CC_PRINT: cmd.op = OP_PUT;
						default:  cmd.op = OP_NONE;
					endcase
				end
			end
			ST_PARSE: begin
				if (!sts.parse_done) cmd.op = OP_PARSE;
				else if (sts.apply_ok) cmd.op = OP_APPLY;
				else cmd.op = OP_REPLAY;
			end
			ST_FILL:   cmd.op = OP_FILL;
			ST_SCROLL: cmd.op = OP_SCROLL;
			ST_NEXT:   if (sts.replay_more) cmd.op = OP_REPLAY_NEXT;
			ST_FINISH: if (sts.out_free) cmd.op = OP_OUT;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ src/text_terminal_escape_controller.sv @@
// Top level of the text terminal escape controller.
// Depends on tte_pkg, tte_if, tte_ctrl and tte_datapath.
//
// A 25x80 character terminal with cursor-control escape sequences. Requests
// are taken one at a time and each gives one result. After reset the screen
// memory is swept to spaces, one cell per cycle, before the first request is
// accepted. A read request goes from ST_RD to ST_FINISH; a plain character
// passes ST_CHAR and ST_NEXT; an escape sequence's bytes are parsed in
// ST_PARSE after its final letter; a scroll and a clear run through the
// single write port of the screen memory, one cell per cycle. A failed
// sequence replays its bytes as text through ST_CHAR and ST_NEXT.
// A finished result is held in an output register while the next request is
// accepted.
module text_terminal_escape_controller (
	input  logic      clk,
	input  logic      arst_n,
	tte_req_if.sink   req,
	tte_rsp_if.source rsp
);
	import tte_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ready;

	tte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tte_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

	assign req.ready = ready;

endmodule

@@ src/tte_checker.sv @@
// Port-level checks of the terminal controller, bound to the top level.
// Depends on tte_pkg.
module tte_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input tte_pkg::ch_t  cell_char,
	input tte_pkg::row_t cursor_row,
	input tte_pkg::col_t cursor_col
);
	import tte_pkg::*;

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_char) &&
		$stable(cursor_row) && $stable(cursor_col))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cursor_row < ROW_W'(ROWS) && cursor_col < COL_W'(COLS))
		else $error("cursor outside the screen");

	// cells only ever hold printables or spaces
	a_cell: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cell_char == '0 || (cell_char >= CH_SPACE && cell_char != CH_DEL))
		else $error("bad cell code");

endmodule

bind text_terminal_escape_controller tte_checker u_tte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.cell_char  (rsp.cell_char),
	.cursor_row (rsp.cursor_row),
	.cursor_col (rsp.cursor_col)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of the text terminal escape controller.
// Needs tte_pkg, tte_if and the block's top level; the screen predictor lives in a small class.
`timescale 1ns / 100ps

module tb_top;
	import tte_pkg::*;

	typedef struct packed {
		logic  req_type;
		ch_t   ch;
		row_t  row;
		col_t  col;
	} term_req_t;

	typedef struct packed {
		ch_t   cell_ch;
		row_t  crow;
		col_t  ccol;
		logic  esc;
	} term_rsp_t;

	class term_scoreboard;
		ch_t       screen [ROWS][COLS];
		int        crow, ccol, srow, scol;
		bit        esc_on;
		int        esc_len;
		ch_t       esc_buf [BUF_DEPTH];
		term_rsp_t pending [$];
		int        errors;

		function void clear_state();
			foreach (screen[r, c]) screen[r][c] = CH_SPACE;
			crow = 0; ccol = 0; srow = 0; scol = 0;
			esc_on = 0; esc_len = 0; errors = 0;
			foreach (esc_buf[i]) esc_buf[i] = '0;
		endfunction

		function void blank(int r, int from, int upto);
			for (int x = from; x <= upto && x < COLS; x++) screen[r][x] = CH_SPACE;
		endfunction

		function void line_feed();
			crow++;
			if (crow >= ROWS) begin
				for (int r = 0; r < ROWS - 1; r++) screen[r] = screen[r+1];
				blank(ROWS - 1, 0, COLS - 1);
				crow = ROWS - 1;
			end
		endfunction

		function int scan_num(ref int pos);
			int v;
			v = 0;
			while (pos < esc_len && esc_buf[pos] >= CH_ZERO && esc_buf[pos] <= CH_NINE) begin
				v = v * 10 + int'(esc_buf[pos] - CH_ZERO);
				if (v > 65535) v = 65535;
				pos++;
			end
			return v;
		endfunction

		function bit run_sequence(ch_t c);
			int pos, n, y, x;
			pos = 1;
			if (esc_len == 0 || esc_buf[0] != CH_LBRK) return 0;
			case (c)
				CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT: begin
					n = scan_num(pos);
					if (pos >= esc_len || esc_buf[pos] != c) return 0;
					if (n == 0) n = 1;
					if (c == CH_UP) crow = (n >= crow) ? 0 : crow - n;
					else if (c == CH_DOWN) crow = (n >= ROWS - 1 - crow) ? ROWS - 1 : crow + n;
					else if (c == CH_RIGHT) ccol = (n >= COLS - 1 - ccol) ? COLS - 1 : ccol + n;
					else ccol = (n >= ccol) ? 0 : ccol - n;
				end
				CH_POS_H, CH_POS_F: begin
					y = scan_num(pos);
					x = 0;
					if (pos < esc_len && esc_buf[pos] == CH_SEMI) begin
						pos++;
						x = scan_num(pos);
					end
					if (pos >= esc_len || esc_buf[pos] != c) return 0;
					ccol = (x < COLS) ? x : COLS - 1;
					crow = (y < ROWS) ? y : ROWS - 1;
				end
				CH_CLR_J: begin
					if (esc_len == 2) begin
						for (int r = crow; r < ROWS; r++) blank(r, 0, COLS - 1);
					end else if (esc_len == 3 && esc_buf[1] == CH_ONE) begin
						for (int r = 0; r <= crow; r++) blank(r, 0, COLS - 1);
					end else if (esc_len == 3 && esc_buf[1] == CH_TWO) begin
						for (int r = 0; r < ROWS; r++) blank(r, 0, COLS - 1);
						crow = 0; ccol = 0;
					end else return 0;
				end
				CH_CLR_K: begin
					if (esc_len == 2) blank(crow, ccol, COLS - 1);
					else if (esc_len == 3 && esc_buf[1] == CH_ONE) blank(crow, 0, ccol);
					else if (esc_len == 3 && esc_buf[1] == CH_TWO) blank(crow, 0, COLS - 1);
					else return 0;
				end
				CH_SAVE: begin
					if (esc_len != 2) return 0;
					srow = crow; scol = ccol;
				end
				default: begin
					if (esc_len != 2) return 0;
					crow = srow; ccol = scol;
				end
			endcase
			return 1;
		endfunction

		function void take_char(ch_t c);
			ch_t copy [BUF_DEPTH];
			int  n;
			if (esc_on) begin
				if (esc_len > ESC_LIMIT) begin
					esc_on = 0; esc_len = 0;
					return;
				end
				esc_buf[esc_len] = c;
				esc_len++;
				if (c inside {CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_POS_H, CH_POS_F,
				              CH_CLR_J, CH_CLR_K, CH_SAVE, CH_REST}) begin
					if (run_sequence(c)) begin
						esc_on = 0; esc_len = 0;
					end else begin
						// failed letter: feed every collected byte back as text
						n = esc_len;
						copy = esc_buf;
						esc_on = 0; esc_len = 0;
						for (int i = 0; i < n; i++) take_char(copy[i]);
					end
				end
				return;
			end
			if (c < CH_SPACE) begin
				case (c)
					CH_ESC: begin esc_on = 1; esc_len = 0; end
					CH_CR: ccol = 0;
					CH_LF: line_feed();
					CH_BS: begin
						if (crow > 0 || ccol > 0) begin
							if (ccol == 0) begin
								ccol = COLS - 1; crow--;
							end else ccol--;
							screen[crow][ccol] = CH_SPACE;
						end
					end
					CH_TAB: begin
						ccol = (ccol / TAB_STEP + 1) * TAB_STEP;
						if (ccol >= COLS) begin
							ccol = 0; line_feed();
						end
					end
					default: ;
				endcase
				return;
			end
			if (c == CH_DEL) return;
			screen[crow][ccol] = c;
			ccol++;
			if (ccol >= COLS) begin
				ccol = 0; line_feed();
			end
		endfunction

		function void note_request(term_req_t q);
			term_rsp_t e;
			e.cell_ch = '0;
			if (!q.req_type) take_char(q.ch);
			else if (q.row < ROWS && q.col < COLS) e.cell_ch = screen[q.row][q.col];
			e.crow = row_t'(crow);
			e.ccol = col_t'(ccol);
			e.esc  = esc_on;
			pending.push_back(e);
		endfunction

		function void check_result(term_rsp_t a);
			term_rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", a);
				return;
			end
			e = pending.pop_front();
			if (a.cell_ch !== e.cell_ch || a.crow !== e.crow || a.ccol !== e.ccol ||
			    a.esc !== e.esc) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: exp cell=%0d row=%0d col=%0d esc=%0d, got cell=%0d row=%0d col=%0d esc=%0d",
					         e.cell_ch, e.crow, e.ccol, e.esc, a.cell_ch, a.crow, a.ccol, a.esc);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;

	tte_req_if req ();
	tte_rsp_if rsp ();

	text_terminal_escape_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	term_scoreboard sb = new();
	term_req_t      stim [$];

	initial clk = 0;
	always #5 clk = ~clk;

	task automatic add_char(ch_t c);
		term_req_t q;
		q.req_type = 0;
		q.ch  = c;
		q.row = row_t'($urandom);
		q.col = col_t'($urandom);
		stim.push_back(q);
	endtask

	task automatic add_read(int r, int c);
		term_req_t q;
		q.req_type = 1;
		q.ch  = ch_t'($urandom);
		q.row = row_t'(r);
		q.col = col_t'(c);
		stim.push_back(q);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_char(ch_t'(s[i]));
	endtask

	task automatic add_esc(string s);
		add_char(CH_ESC);
		add_text(s);
	endtask

	function automatic string count_text(int hi);
		if ($urandom_range(3) == 0) return "";
		return $sformatf("%0d", $urandom_range(hi));
	endfunction

	// one character of the given set, picked at random
	function automatic string pick_one(string set);
		int k;
		k = $urandom_range(set.len() - 1);
		return set.substr(k, k);
	endfunction

	task automatic add_random_request();
		int    pick, m;
		string s;
		pick = $urandom_range(99);
		if (pick < 28) begin
			add_char(ch_t'($urandom_range(32, 127)));
		end else if (pick < 43) begin
			if ($urandom_range(4) == 0) add_read($urandom_range(31), $urandom_range(127));
			else add_read($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
		end else if (pick < 53) begin
			m = $urandom_range(5);
			case (m)
				0: add_char(CH_CR);
				1: add_char(CH_LF);
				2, 3: add_char(CH_BS);
				4: add_char(CH_TAB);
				default: add_char(ch_t'($urandom_range(31)));
			endcase
		end else if (pick < 88) begin
			m = $urandom_range(7);
			case (m)
				0: s = {count_text(30), pick_one("ABCD")};
				1, 2: s = {count_text(30), ";", count_text(90), ($urandom_range(1) ? "H" : "f")};
				3: s = {count_text(30), ($urandom_range(1) ? "H" : "f")};
				4: s = {(($urandom_range(2) == 0) ? "" : $sformatf("%0d", $urandom_range(2))),
				        ($urandom_range(2) == 0 ? "J" : "K")};
				5: s = "s";
				6: s = "u";
				default: s = {$sformatf("%0d", $urandom_range(99999)), pick_one("ABCD")};
			endcase
			add_esc({"[", s});
		end else begin
			m = $urandom_range(3);
			case (m)
				0: add_esc({"[", $sformatf("%0d", $urandom_range(3, 9)), pick_one("Ks")});
				1: add_esc({"x", pick_one("ABu")});
				2: begin
					add_char(CH_ESC);
					m = $urandom_range(20, 26);
					for (int i = 0; i < m; i++)
						add_char(ch_t'($urandom_range(48, 59)));
				end
				default: begin
					add_esc("[");
					add_char(ch_t'($urandom_range(127)));
					add_char(CH_RIGHT);
				end
			endcase
		end
	endtask

	task automatic send_all();
		int idx;
		idx = 0;
		while (stim.size() > 0) begin
			term_req_t q;
			q = stim.pop_front();
			calm = (idx >= 120 && idx < 190);
			if (idx == 200) begin
				// hold off until the block has drained
				req.valid <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end else if (!calm && $urandom_range(99) < 26) begin
				req.valid <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			req.valid    <= 1;
			req.req_type <= q.req_type;
			req.char_in  <= q.ch;
			req.read_row <= q.row;
			req.read_col <= q.col;
			@(posedge clk);
			while (!req.ready) @(posedge clk);
			sb.note_request(q);
			idx++;
		end
		req.valid <= 0;
	endtask

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_result({rsp.cell_char, rsp.cursor_row, rsp.cursor_col, rsp.in_escape});
		if (arst_n) rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
	end

	initial begin
		req.valid    = 0;
		req.req_type = 0;
		req.char_in  = '0;
		req.read_row = '0;
		req.read_col = '0;
		rsp.ready    = 0;
		arst_n       = 0;
		calm         = 0;
		sb.clear_state();

		// directed opening
		add_read(0, 0);
		add_read(31, 127);
		add_char(CH_BS);
		add_char('0);
		add_char(CH_DEL);
		add_text("~ ");
		add_esc("[24;79H");
		add_text("Z");
		add_char(CH_TAB);
		add_esc("[99999A");
		add_esc("[s");
		add_esc("[B");
		add_esc("[0D");
		add_esc("[u");
		add_esc("[1K");
		add_esc("[3J");
		add_esc("[");
		add_esc("[C");
		add_read(24, 79);
		add_read(25, 0);
		add_esc("[2J");

		while (stim.size() < 320) add_random_request();

		repeat (3) @(posedge clk);
		arst_n <= 1;
		send_all();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#100ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
